>>> rtl/ppp_pkg.sv
package ppp_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int COEF_BITS_DEF  = 16;
  localparam int LANE_BITS      = 16;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int OUT_W          = 40;
  localparam int OUT_FRAC       = 16;
  localparam int SUM_FRAC       = 20;
  localparam int COEF_FRAC      = 12;
  localparam int ONE_SHIFT      = SUM_FRAC - COEF_FRAC;
  localparam int BEHIND_SHIFT   = SUM_FRAC - OUT_FRAC;
  localparam int QUO_W          = OUT_W + 1;
  localparam int DIV_OVF_SHIFT  = QUO_W - OUT_FRAC;
  localparam int BPROD_W        = 48;
  localparam int W_THRESH       = 1049;
  localparam int BEHIND_SCALE   = 100000;
  localparam logic [63:0] BEHIND_LIMIT = 64'd1 << 30;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W = 2'd2;

  typedef struct packed {
    logic behind;
    logic neg_x;
    logic neg_y;
    logic dov_x;
    logic dov_y;
    logic bov_x;
    logic bov_y;
  } ppp_flags_t;

  // sign and saturate a magnitude to the 40-bit result range
  function automatic logic [OUT_W-1:0] sat_out(input logic neg,
                                               input logic [BPROD_W-1:0] mag,
                                               input logic over);
    logic [BPROD_W-1:0] lim;
    logic [BPROD_W-1:0] m;
    lim = BPROD_W'(1) << (OUT_W - 1);
    m   = mag;
    if (neg) begin
      if (over || m > lim) m = lim;
      sat_out = OUT_W'(BPROD_W'(0) - m);
    end else begin
      if (over || m > lim - BPROD_W'(1)) m = lim - BPROD_W'(1);
      sat_out = OUT_W'(m);
    end
  endfunction

endpackage

>>> rtl/ppp_front.sv
module ppp_front #(
  parameter int COORD_BITS = 24,
  parameter int COEF_BITS  = 16,
  parameter int SUM_W      = COORD_BITS + COEF_BITS + 2
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [2:0][COORD_BITS-1:0]             pos,
  input  logic [2:0][ppp_pkg::CFG_W-1:0]         rows,
  output logic                                   out_valid,
  output ppp_pkg::ppp_flags_t                    flags,
  output logic [SUM_W-1:0]                       d,
  output logic [SUM_W-1:0]                       mag_x,
  output logic [SUM_W-1:0]                       mag_y,
  output logic [ppp_pkg::BPROD_W-1:0]            bprod_x,
  output logic [ppp_pkg::BPROD_W-1:0]            bprod_y
);
  import ppp_pkg::*;

  localparam int PW = COORD_BITS + COEF_BITS;

  logic signed [COEF_BITS-1:0]  cf [3][4];
  logic signed [PW-1:0]         prod [3][3];
  logic signed [SUM_W-1:0]      sum [3];
  logic signed [SUM_W-1:0]      sx, sy, sw;
  logic [SUM_W-1:0]             ax, ay;
  logic [30:0]                  mx31, my31;
  logic                         v1, v2;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign cf[r][c] = rows[r][c*LANE_BITS +: COEF_BITS];
    end
  end

  assign sx = sum[0];
  assign sy = sum[1];
  assign sw = sum[2];
  assign ax = sx[SUM_W-1] ? SUM_W'(-sx) : SUM_W'(sx);
  assign ay = sy[SUM_W-1] ? SUM_W'(-sy) : SUM_W'(sy);
  assign mx31 = 31'(64'(ax));
  assign my31 = 31'(64'(ay));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= PW'(cf[r][c]) * PW'($signed(pos[c]));
        end
        sum[r] <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2])
                + (SUM_W'(cf[r][3]) <<< ONE_SHIFT);
      end
      flags.behind <= (64'(sw) < 64'(W_THRESH)) || sw[SUM_W-1];
      flags.neg_x  <= sx[SUM_W-1];
      flags.neg_y  <= sy[SUM_W-1];
      flags.dov_x  <= (ax >> DIV_OVF_SHIFT) >= SUM_W'(sw);
      flags.dov_y  <= (ay >> DIV_OVF_SHIFT) >= SUM_W'(sw);
      flags.bov_x  <= 64'(ax) > BEHIND_LIMIT;
      flags.bov_y  <= 64'(ay) > BEHIND_LIMIT;
      d            <= SUM_W'(sw);
      mag_x        <= ax;
      mag_y        <= ay;
      bprod_x      <= BPROD_W'(mx31) * BPROD_W'(BEHIND_SCALE);
      bprod_y      <= BPROD_W'(my31) * BPROD_W'(BEHIND_SCALE);
    end
  end

endmodule

>>> rtl/ppp_cell.sv
module ppp_cell #(
  parameter int SUM_W  = 42,
  parameter int REM_W  = 58,
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [SUM_W-1:0]              in_d,
  input  logic [REM_W-1:0]              in_rem_x,
  input  logic [REM_W-1:0]              in_rem_y,
  input  logic [ppp_pkg::QUO_W-1:0]     in_quo_x,
  input  logic [ppp_pkg::QUO_W-1:0]     in_quo_y,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [SUM_W-1:0]              out_d,
  output logic [REM_W-1:0]              out_rem_x,
  output logic [REM_W-1:0]              out_rem_y,
  output logic [ppp_pkg::QUO_W-1:0]     out_quo_x,
  output logic [ppp_pkg::QUO_W-1:0]     out_quo_y,
  output logic [SIDE_W-1:0]             out_side
);
  import ppp_pkg::*;

  logic [REM_W-1:0] dsh;
  logic             qx, qy;

  // one restoring quotient bit per lane, weight 2^SHIFT
  assign dsh = REM_W'(in_d) << SHIFT;
  assign qx  = (in_rem_x >> SHIFT) >= REM_W'(in_d);
  assign qy  = (in_rem_y >> SHIFT) >= REM_W'(in_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_d     <= in_d;
      out_rem_x <= qx ? in_rem_x - dsh : in_rem_x;
      out_rem_y <= qy ? in_rem_y - dsh : in_rem_y;
      out_quo_x <= {in_quo_x[QUO_W-2:0], qx};
      out_quo_y <= {in_quo_y[QUO_W-2:0], qy};
      out_side  <= in_side;
    end
  end

endmodule

>>> rtl/perspective_point_projection_core.sv
// Perspective point projection. Each transfer on s_axis carries one Q16.8
// point; the core forms X, Y and W from matrix rows 0, 1 and 3 (written on
// the cfg port while idle) and returns one transfer on m_axis: X/W and Y/W
// in Q24.16, saturated, or, when W is below 0.001, X and Y times 100000 with
// tuser set. Throughput is one point per clock. The pipe is the multiply,
// sum and sign/scale setup registers, a chain of 41 divider cells that each
// settle one quotient bit for both X and Y, and the output register. The
// whole pipe holds while a result waits on m_axis.
module perspective_point_projection_core #(
  parameter int COORD_BITS = ppp_pkg::COORD_BITS_DEF,
  parameter int COEF_BITS  = ppp_pkg::COEF_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // config write port
  input  logic                                 cfg_we,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppp_pkg::CFG_W-1:0]            cfg_data,
  // points in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata, low bit up: pos_x, pos_y, pos_z, zero fill
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // results out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata, low bit up: proj_x, proj_y
  output logic [2*ppp_pkg::OUT_W-1:0]          m_axis_tdata,
  // tuser: is_behind
  output logic                                 m_axis_tuser
);
  import ppp_pkg::*;

  localparam int SUM_W  = COORD_BITS + COEF_BITS + 2;
  localparam int REM_W  = SUM_W + OUT_FRAC;
  localparam int FLAG_W = $bits(ppp_flags_t);
  localparam int SIDE_W = FLAG_W + 2*BPROD_W;

  logic [2:0][CFG_W-1:0]      rows;
  logic [2:0][COORD_BITS-1:0] pos;
  logic                       en;

  logic                       fv;
  ppp_flags_t                 ff;
  logic [SUM_W-1:0]           fd, fmx, fmy;
  logic [BPROD_W-1:0]         fbx, fby;

  logic                       cv   [QUO_W+1];
  logic [SUM_W-1:0]           cd   [QUO_W+1];
  logic [REM_W-1:0]           crx  [QUO_W+1];
  logic [REM_W-1:0]           cry  [QUO_W+1];
  logic [QUO_W-1:0]           cqx  [QUO_W+1];
  logic [QUO_W-1:0]           cqy  [QUO_W+1];
  logic [SIDE_W-1:0]          cside[QUO_W+1];

  ppp_flags_t                 lf;
  logic [BPROD_W-1:0]         lbx, lby;
  logic [OUT_W-1:0]           px_next, py_next;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_X: rows[0] <= cfg_data;
        REG_ROW_Y: rows[1] <= cfg_data;
        REG_ROW_W: rows[2] <= cfg_data;
        default:   ;
      endcase
    end
  end

  // global advance: everything moves unless a finished result is stuck
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar i = 0; i < 3; i++) begin : g_pos
    assign pos[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
  end

  ppp_front #(
    .COORD_BITS(COORD_BITS),
    .COEF_BITS (COEF_BITS),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .pos      (pos),
    .rows     (rows),
    .out_valid(fv),
    .flags    (ff),
    .d        (fd),
    .mag_x    (fmx),
    .mag_y    (fmy),
    .bprod_x  (fbx),
    .bprod_y  (fby)
  );

  // dividend is |v| scaled to Q.16 of the quotient
  assign cv[0]    = fv;
  assign cd[0]    = fd;
  assign crx[0]   = REM_W'(fmx) << OUT_FRAC;
  assign cry[0]   = REM_W'(fmy) << OUT_FRAC;
  assign cqx[0]   = '0;
  assign cqy[0]   = '0;
  assign cside[0] = {ff, fbx, fby};

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    ppp_cell #(
      .SUM_W (SUM_W),
      .REM_W (REM_W),
      .SHIFT (QUO_W - 1 - k),
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (cv[k]),
      .in_d     (cd[k]),
      .in_rem_x (crx[k]),
      .in_rem_y (cry[k]),
      .in_quo_x (cqx[k]),
      .in_quo_y (cqy[k]),
      .in_side  (cside[k]),
      .out_valid(cv[k+1]),
      .out_d    (cd[k+1]),
      .out_rem_x(crx[k+1]),
      .out_rem_y(cry[k+1]),
      .out_quo_x(cqx[k+1]),
      .out_quo_y(cqy[k+1]),
      .out_side (cside[k+1])
    );
  end

  assign lf  = ppp_flags_t'(cside[QUO_W][SIDE_W-1 -: FLAG_W]);
  assign lbx = cside[QUO_W][2*BPROD_W-1 -: BPROD_W];
  assign lby = cside[QUO_W][BPROD_W-1:0];

  // behind: scaled magnitude drops the extra fraction bits; else quotient
  assign px_next = lf.behind ? sat_out(lf.neg_x, lbx >> BEHIND_SHIFT, lf.bov_x)
                             : sat_out(lf.neg_x, BPROD_W'(cqx[QUO_W]), lf.dov_x);
  assign py_next = lf.behind ? sat_out(lf.neg_y, lby >> BEHIND_SHIFT, lf.bov_y)
                             : sat_out(lf.neg_y, BPROD_W'(cqy[QUO_W]), lf.dov_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= cv[QUO_W];
    end
    if (en) begin
      m_axis_tdata <= {py_next, px_next};
      m_axis_tuser <= lf.behind;
    end
  end

endmodule

>>> rtl/ppp_check.sv
module ppp_check #(
  parameter int COORD_BITS = 24
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [((3*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [2*ppp_pkg::OUT_W-1:0]          m_axis_tdata,
  input logic                                 m_axis_tuser
);

  // input side moves exactly when the output side is free
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("s_axis_tready does not track output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

endmodule

bind perspective_point_projection_core ppp_check #(.COORD_BITS(COORD_BITS)) u_ppp_check (.*);
